// ===== sv/fh64_pkg.sv =====
// Shared package for the fasthash64 string hash block.
// Holds constants, controller and operation codes, and command/status types.
// Depends on nothing; every other file imports it.
`default_nettype none

package fh64_pkg;

  // Field widths.
  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int COUNT_W = 4;
  localparam int LEN_W   = 16;

  // Hash constants.
  localparam logic [WORD_W-1:0] FH_MULT  = 64'h8803_55f2_1e6d_1965;
  localparam logic [WORD_W-1:0] MIX_MULT = 64'h2127_599b_f432_5c37;
  localparam int MIX_SHA = 23;
  localparam int MIX_SHB = 47;

  // Number of bytes in a full word.
  localparam logic [COUNT_W-1:0] BYTES_PER_WORD = 4'd8;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIXW,
    ST_FOLD,
    ST_FIN,
    ST_EMIT
  } state_t;

  // Multiply operations run by the datapath.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEED,
    OP_MIXW,
    OP_FOLD,
    OP_FIN
  } op_t;

  // Partial product steps of one 64-bit multiply.
  typedef logic [1:0] step_t;
  localparam step_t STEP_LO   = 2'd0;
  localparam step_t STEP_HL   = 2'd1;
  localparam step_t STEP_LAST = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic  load;
    op_t   op;
    step_t step;
    logic  emit;
  } fh_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_last;
    logic in_fold;
    logic fold;
    logic last;
    logic out_free;
  } fh_status_t;

  // First half of the mix function.
  function automatic logic [WORD_W-1:0] mix_pre(input logic [WORD_W-1:0] v);
    return v ^ (v >> MIX_SHA);
  endfunction

  // Last half of the mix function, applied after the multiply.
  function automatic logic [WORD_W-1:0] mix_post(input logic [WORD_W-1:0] v);
    return v ^ (v >> MIX_SHB);
  endfunction

endpackage

`default_nettype wire

// ===== sv/fh64_if.sv =====
// Channel interfaces for the fasthash64 block: string words in, digests out.
// Depends on fh64_pkg for field widths.
`default_nettype none

interface fh64_msg_if import fh64_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  word_data;
  logic [COUNT_W-1:0] byte_count;
  logic [LEN_W-1:0]   string_length;
  logic               last_word;

  modport source (output valid, word_data, byte_count, string_length, last_word,
                  input ready);
  modport sink   (input valid, word_data, byte_count, string_length, last_word,
                  output ready);
endinterface

interface fh64_digest_if import fh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== sv/fh64_datapath.sv =====
// Datapath of the fasthash64 block: item registers, running hash and a
// shared 32x32 multiplier that builds each 64-bit product in three steps.
// Depends on fh64_pkg.
`default_nettype none

module fh64_datapath import fh64_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fh_cmd_t            cmd,
  output fh_status_t              status,
  input  wire logic [WORD_W-1:0]  word_data,
  input  wire logic [COUNT_W-1:0] byte_count,
  input  wire logic [LEN_W-1:0]   string_length,
  input  wire logic               last_word,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [WORD_W-1:0]       hash_value
);

  logic [WORD_W-1:0] word_r;
  logic [LEN_W-1:0]  len_r;
  logic              fold_r;
  logic              last_r;
  logic [WORD_W-1:0] hash_r;
  logic [WORD_W-1:0] acc_r;

  logic              in_full;
  logic [WORD_W-1:0] byte_mask;
  logic [WORD_W-1:0] op_a;
  logic [WORD_W-1:0] op_b;
  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] prod_sum;

  // Bytes at and above the count are cleared on a final partial word.
  always_comb begin
    in_full   = !last_word || (byte_count >= BYTES_PER_WORD);
    byte_mask = in_full ? {WORD_W{1'b1}}
                        : ~({WORD_W{1'b1}} << {byte_count[2:0], 3'b000});
  end

  // Operand selection for the current multiply.
  always_comb begin
    case (cmd.op)
      OP_SEED: op_a = {{(WORD_W-LEN_W){1'b0}}, len_r};
      OP_MIXW: op_a = mix_pre(word_r);
      OP_FOLD: op_a = hash_r;
      OP_FIN:  op_a = mix_pre(hash_r);
      default: op_a = hash_r;
    endcase
    op_b = ((cmd.op == OP_SEED) || (cmd.op == OP_FOLD)) ? FH_MULT : MIX_MULT;
  end

  // One partial product per step; only the low 64 bits of the full product are kept.
  always_comb begin
    case (cmd.step)
      STEP_LO: begin
        mul_x = op_a[HALF_W-1:0];
        mul_y = op_b[HALF_W-1:0];
      end
      STEP_HL: begin
        mul_x = op_a[WORD_W-1:HALF_W];
        mul_y = op_b[HALF_W-1:0];
      end
      default: begin
        mul_x = op_a[HALF_W-1:0];
        mul_y = op_b[WORD_W-1:HALF_W];
      end
    endcase
    prod     = mul_x * mul_y;
    prod_sum = (cmd.step == STEP_LO) ? prod
                                     : acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  // Item registers, captured when a request is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= word_data & byte_mask;
      len_r  <= string_length;
      fold_r <= !last_word || (byte_count != '0);
      last_r <= last_word;
    end
  end

  // Accumulator and running hash updates; the finishing multiply leaves the
  // completed digest in the accumulator.
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      if ((cmd.op == OP_FIN) && (cmd.step == STEP_LAST)) begin
        acc_r <= mix_post(prod_sum);
      end else begin
        acc_r <= prod_sum;
      end
      if (cmd.step == STEP_LAST) begin
        case (cmd.op)
          OP_SEED: hash_r <= prod_sum;
          OP_MIXW: hash_r <= hash_r ^ mix_post(prod_sum);
          OP_FOLD: hash_r <= prod_sum;
          default: hash_r <= hash_r;
        endcase
      end
    end
  end

  // Output register: the digest waits here while the next string is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hash_value <= acc_r;
    end
  end

  // Status towards the controller.
  always_comb begin
    status.in_last  = last_word;
    status.in_fold  = !last_word || (byte_count != '0);
    status.fold     = fold_r;
    status.last     = last_r;
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== sv/fh64_ctrl.sv =====
// Controller of the fasthash64 block: sequences seed, mix, fold and finish
// multiplies and tracks whether a string is in progress.
// Depends on fh64_pkg.
`default_nettype none

module fh64_ctrl import fh64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire fh_status_t status,
  output fh_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  step_t  step;
  logic   inside_string;
  logic   step_done;
  logic   mul_busy;

  always_comb begin
    step_done = (step == STEP_LAST);
    mul_busy  = (state == ST_SEED) || (state == ST_MIXW) ||
                (state == ST_FOLD) || (state == ST_FIN);
  end

  // State, step counter and string tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= STEP_LO;
      inside_string <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_busy && !step_done) begin
        step <= step + 2'd1;
      end else begin
        step <= STEP_LO;
      end
      if ((state == ST_IDLE) && in_valid) begin
        inside_string <= !status.in_last;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!inside_string) begin
            state_next = ST_SEED;
          end else if (status.in_fold) begin
            state_next = ST_MIXW;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_SEED: begin
        if (step_done) begin
          state_next = status.fold ? ST_MIXW : ST_FIN;
        end
      end
      ST_MIXW: begin
        if (step_done) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (step_done) begin
          state_next = status.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (step_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.step = step;
    cmd.emit = (state == ST_EMIT) && status.out_free;
    case (state)
      ST_SEED: cmd.op = OP_SEED;
      ST_MIXW: cmd.op = OP_MIXW;
      ST_FOLD: cmd.op = OP_FOLD;
      ST_FIN:  cmd.op = OP_FIN;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/fasthash64_string_hash_top.sv =====
// fasthash64 string hash, top level. One request is taken at a time.
// A non-final word runs mix and fold multiplies, seeded first if it opens a string.
// A final word runs the finish multiply, after any seed, mix and fold it needs;
// every multiply is three passes through the one shared 32x32 multiplier.
// The digest sits in an output register, so the next string may start while it waits.
// Synchronous active-high reset returns the controller to idle with no string open.
`default_nettype none

module fasthash64_string_hash_top import fh64_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  fh64_msg_if.sink     msg,
  fh64_digest_if.source digest
);

  fh_cmd_t    cmd;
  fh_status_t status;

  // Sequencer.
  fh64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_ready (msg.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  fh64_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .word_data     (msg.word_data),
    .byte_count    (msg.byte_count),
    .string_length (msg.string_length),
    .last_word     (msg.last_word),
    .out_ready     (digest.ready),
    .out_valid     (digest.valid),
    .hash_value    (digest.hash_value)
  );

endmodule

`default_nettype wire

// ===== sv/fh64_checker.sv =====
// Port-level checks for the fasthash64 block, bound to the top level.
// Depends on fh64_pkg and the top level's channel interfaces.
`default_nettype none

module fh64_checker import fh64_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] hash_value
);

  // One request at a time: the input closes after each acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input stayed open after a request was accepted");

  // A digest takes several multiply steps, never rising at once.
  a_no_instant_digest: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !$rose(out_valid))
    else $error("digest appeared one cycle after the final word");

  // A stalled digest stays offered.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("digest withdrawn while stalled");

  // A stalled digest keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(hash_value))
    else $error("digest changed while stalled");

endmodule

bind fasthash64_string_hash_top fh64_checker u_fh64_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (msg.valid),
  .in_ready   (msg.ready),
  .in_last    (msg.last_word),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .hash_value (digest.hash_value)
);

`default_nettype wire
